// ===== src/rncp_pkg.sv =====
// Shared types, character codes and the numeral transition table of the chord parser.
`default_nettype none

package rncp_pkg;

    localparam int MAX_LEN_DEF = 16;

    localparam logic [7:0] CHAR_SHARP   = 8'h23;
    localparam logic [7:0] CHAR_FLAT    = 8'h62;
    localparam logic [7:0] CHAR_UPPER_I = 8'h49;
    localparam logic [7:0] CHAR_UPPER_V = 8'h56;
    localparam logic [7:0] CHAR_LOWER_I = 8'h69;
    localparam logic [7:0] CHAR_LOWER_V = 8'h76;

    localparam logic [3:0] ACC_LIMIT = 4'd15;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_NUMERAL,
        PH_SUFFIX
    } phase_t;

    // Running parse state of one token, without the length counter.
    typedef struct packed {
        phase_t     phase;
        logic [2:0] numeral_pattern;
        logic [1:0] case_seen;
        logic [3:0] acc_count;
        logic [1:0] acc_kinds_seen;
        logic       had_prefix;
        logic       error_flag;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:           PH_PREFIX,
        numeral_pattern: 3'd0,
        case_seen:       2'd0,
        acc_count:       4'd0,
        acc_kinds_seen:  2'd0,
        had_prefix:      1'b0,
        error_flag:      1'b0
    };

    typedef struct packed {
        logic              valid_res;
        logic [2:0]        degree;
        logic              major;
        logic signed [4:0] accidental_offset;
    } chord_result_t;

    // Numeral read so far after one more letter; zero means no legal numeral.
    function automatic logic [2:0] next_pattern(input logic [2:0] pat, input logic is_v);
        logic [2:0] np;
        case (pat)
            3'd0:    np = is_v ? 3'd5 : 3'd1;
            3'd1:    np = is_v ? 3'd4 : 3'd2;
            3'd2:    np = is_v ? 3'd0 : 3'd3;
            3'd5:    np = is_v ? 3'd0 : 3'd6;
            3'd6:    np = is_v ? 3'd0 : 3'd7;
            default: np = 3'd0;
        endcase
        return np;
    endfunction

endpackage

`default_nettype wire

// ===== src/rncp_step.sv =====
// Next-state and result logic for one character of a chord token.
`default_nettype none

module rncp_step
    import rncp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int CNT_W  = $clog2(MAX_LEN + 2)
) (
    input  wire logic [7:0]       char_in,
    input  wire logic             last_char,
    input  wire parse_state_t     state_cur,
    input  wire logic [CNT_W-1:0] count_cur,
    output parse_state_t          state_next,
    output logic [CNT_W-1:0]      count_next,
    output chord_result_t         result
);

    logic       is_acc;
    logic       is_upper;
    logic       is_lower;
    logic       is_v;
    logic [2:0] np;
    logic       ok;
    logic [4:0] acc_ext;
    parse_state_t st;
    logic [CNT_W-1:0] cnt;

    assign is_acc   = (char_in == CHAR_SHARP) || (char_in == CHAR_FLAT);
    assign is_upper = (char_in == CHAR_UPPER_I) || (char_in == CHAR_UPPER_V);
    assign is_lower = (char_in == CHAR_LOWER_I) || (char_in == CHAR_LOWER_V);
    assign is_v     = (char_in == CHAR_UPPER_V) || (char_in == CHAR_LOWER_V);
    assign np       = next_pattern(state_cur.numeral_pattern, is_v);

    always_comb begin
        st  = state_cur;
        cnt = count_cur;
        // The length counter stops one past the limit so overlong tokens stay flagged.
        if (count_cur <= CNT_W'(MAX_LEN)) begin
            cnt = count_cur + CNT_W'(1);
        end
        if (is_acc) begin
            if (state_cur.phase == PH_NUMERAL) begin
                st.phase = PH_SUFFIX;
                if (state_cur.had_prefix) begin
                    st.error_flag = 1'b1;
                end
            end else if (state_cur.phase == PH_PREFIX) begin
                st.had_prefix = 1'b1;
            end
            if (state_cur.acc_count < ACC_LIMIT) begin
                st.acc_count = state_cur.acc_count + 4'd1;
            end
            st.acc_kinds_seen = state_cur.acc_kinds_seen |
                                ((char_in == CHAR_SHARP) ? 2'b01 : 2'b10);
        end else if (is_upper || is_lower) begin
            if (state_cur.phase == PH_SUFFIX) begin
                st.error_flag = 1'b1;
            end else begin
                st.phase = PH_NUMERAL;
                if (np == 3'd0) begin
                    st.error_flag = 1'b1;
                end else begin
                    st.numeral_pattern = np;
                end
                st.case_seen = state_cur.case_seen | (is_upper ? 2'b01 : 2'b10);
            end
        end else begin
            st.error_flag = 1'b1;
        end
    end

    assign ok = !st.error_flag && (st.phase != PH_PREFIX) && (st.numeral_pattern != 3'd0) &&
                (st.acc_kinds_seen != 2'b11) && (st.case_seen != 2'b11) &&
                (cnt <= CNT_W'(MAX_LEN));
    assign acc_ext = {1'b0, st.acc_count};

    always_comb begin
        result.valid_res = ok;
        result.degree    = ok ? st.numeral_pattern : 3'd0;
        result.major     = ok && (st.case_seen == 2'b01);
        if (!ok) begin
            result.accidental_offset = 5'sd0;
        end else if (st.acc_kinds_seen == 2'b01) begin
            result.accidental_offset = $signed(acc_ext);
        end else begin
            // Flats only (or none, where the count is zero): negative offset.
            result.accidental_offset = $signed(5'd0 - acc_ext);
        end
    end

    // The last character closes the token and returns the parser to its start.
    assign state_next = last_char ? STATE_RESET : st;
    assign count_next = last_char ? '0 : cnt;

endmodule

`default_nettype wire

// ===== src/roman_numeral_chord_parser_core.sv =====
// Roman numeral chord parser: streams token characters in, one parse result per token out.
//
// Input channel (s_): one character per item in s_tdata, with s_tlast on the final
// character of a token. Accidentals ('#' or 'b') may lead or trail a numeral I..VII
// written all upper or all lower case; anything else yields an invalid result.
// Result channel (m_): one item per token, issued for the item carrying s_tlast.
// m_tuser is the valid flag; m_tdata holds degree, major and the signed offset.
//
// Throughput is one character per cycle: the parse state updates in one pass of
// short logic between the state registers and the result register.
// m_tvalid rises in the cycle after the accepted last character.
// The result register is a single stage; while it holds a result the receiver has
// not taken, s_tready stays high only in cycles where m_tready drains it, so a
// stalled receiver holds back every input character, not only a token's last one.
// Reset clears the parse state and the result valid flag; the first character after
// reset starts a new token. Tokens longer than MAX_LEN characters parse as invalid.
`default_nettype none

module roman_numeral_chord_parser_core
    import rncp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [2:0] degree, [3] major, [8:4] accidental_offset
    output logic             m_tuser    // valid_res
);

    localparam int CNT_W = $clog2(MAX_LEN + 2);

    parse_state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    chord_result_t    result_reg, result_next;
    logic             m_tvalid_reg;
    logic             s_accept;

    rncp_step #(
        .MAX_LEN(MAX_LEN)
    ) u_step (
        .char_in   (s_tdata),
        .last_char (s_tlast),
        .state_cur (state_reg),
        .count_cur (count_reg),
        .state_next(state_next),
        .count_next(count_next),
        .result    (result_next)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (s_accept && s_tlast) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.valid_res;
    assign m_tdata  = {7'd0, result_reg.accidental_offset, result_reg.major, result_reg.degree};

    a_last_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (count_reg == '0) && (state_reg == STATE_RESET))
        else $error("parse state not cleared after the last character");

    a_inner_char_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tlast) |=> (count_reg != '0))
        else $error("character counter did not advance inside a token");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("invalid result carries nonzero fields");

    a_valid_has_degree: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (result_reg.degree != 3'd0))
        else $error("valid result without a scale degree");

endmodule

`default_nettype wire

// ===== dv/roman_numeral_chord_parser_core_test.sv =====
// Self-checking stream testbench for the Roman numeral chord parser core.
`timescale 1ns / 1ps

module roman_numeral_chord_parser_core_test;
    import rncp_pkg::*;

    localparam int MAX_LEN    = MAX_LEN_DEF;
    localparam int RAND_ITEMS = 1150;

    localparam chord_result_t NO_CHORD = '0;

    localparam logic [7:0] SYMBOLS [6] = '{
        CHAR_SHARP, CHAR_FLAT, CHAR_UPPER_I, CHAR_UPPER_V, CHAR_LOWER_I, CHAR_LOWER_V
    };

    typedef struct {
        logic [7:0]    ch;
        bit            last;
        bit            typed;   // the row carries its own expected chord
        chord_result_t res;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    roman_numeral_chord_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Parse state of the token being read, mirrored from the block's behavior.
    phase_t     tok_phase   = PH_PREFIX;
    logic [2:0] tok_pattern = 3'd0;
    logic [1:0] tok_case    = 2'b00;
    logic [3:0] tok_acc     = 4'd0;
    logic [1:0] tok_kinds   = 2'b00;
    bit         tok_prefix  = 1'b0;
    int         tok_len     = 0;
    bit         tok_err     = 1'b0;

    chord_result_t chord_q [$];
    logic [7:0]    tok_chars [$];

    bit            cur_typed = 1'b0;
    chord_result_t cur_res   = '0;
    bit            quiet     = 1'b0;
    int            fail_cnt  = 0;
    int            chars_seen = 0;
    int            chords_seen = 0;
    int            chords_valid = 0;
    int            chars_sent = 0;

    // Directed items: the error cases and both numeral cases, with the extreme byte
    // values; overlong tokens come from the random part.
    stim_row_t dir_rows [$] = '{
        '{CHAR_UPPER_I, 1'b1, 1'b1, '{1'b1, 3'd1, 1'b1, 5'sd0}},
        '{CHAR_LOWER_V, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_LOWER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_LOWER_I, 1'b1, 1'b1, '{1'b1, 3'd7, 1'b0, 5'sd0}},
        '{CHAR_SHARP,   1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_V, 1'b1, 1'b0, NO_CHORD},
        '{CHAR_FLAT,    1'b0, 1'b0, NO_CHORD},
        '{CHAR_FLAT,    1'b0, 1'b0, NO_CHORD},
        '{CHAR_LOWER_V, 1'b1, 1'b0, NO_CHORD},
        '{CHAR_UPPER_V, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_SHARP,   1'b1, 1'b0, NO_CHORD},
        '{CHAR_SHARP,   1'b0, 1'b0, NO_CHORD},
        '{CHAR_FLAT,    1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_I, 1'b1, 1'b1, NO_CHORD},
        '{CHAR_SHARP,   1'b0, 1'b0, NO_CHORD},
        '{CHAR_LOWER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_FLAT,    1'b1, 1'b1, NO_CHORD},
        '{CHAR_UPPER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_SHARP,   1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_I, 1'b1, 1'b1, NO_CHORD},
        '{CHAR_UPPER_I, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_LOWER_V, 1'b1, 1'b1, NO_CHORD},
        '{CHAR_FLAT,    1'b1, 1'b1, NO_CHORD},
        '{8'h00,        1'b1, 1'b1, NO_CHORD},
        '{8'hFF,        1'b1, 1'b1, NO_CHORD},
        '{CHAR_UPPER_V, 1'b0, 1'b0, NO_CHORD},
        '{CHAR_UPPER_V, 1'b1, 1'b1, NO_CHORD}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [2:0] numeral_after(input logic [2:0] pat, input bit is_v);
        case ({pat, is_v})
            4'b000_0: return 3'd1;
            4'b000_1: return 3'd5;
            4'b001_0: return 3'd2;
            4'b001_1: return 3'd4;
            4'b010_0: return 3'd3;
            4'b101_0: return 3'd6;
            4'b110_0: return 3'd7;
            default:  return 3'd0;
        endcase
    endfunction

    // Advances the token state by one character; returns 1 when a chord is due.
    function automatic bit parse_char(input logic [7:0] c, input bit last,
                                      output chord_result_t res);
        bit         is_acc;
        bit         is_up;
        bit         is_lo;
        bit         ok;
        logic [2:0] np;
        is_acc = (c == CHAR_SHARP) || (c == CHAR_FLAT);
        is_up  = (c == CHAR_UPPER_I) || (c == CHAR_UPPER_V);
        is_lo  = (c == CHAR_LOWER_I) || (c == CHAR_LOWER_V);
        res = NO_CHORD;
        if (tok_len <= MAX_LEN) tok_len++;
        if (is_acc) begin
            if (tok_phase == PH_NUMERAL) begin
                tok_phase = PH_SUFFIX;
                if (tok_prefix) tok_err = 1'b1;
            end else if (tok_phase == PH_PREFIX) begin
                tok_prefix = 1'b1;
            end
            if (tok_acc < ACC_LIMIT) tok_acc++;
            tok_kinds |= (c == CHAR_SHARP) ? 2'b01 : 2'b10;
        end else if (is_up || is_lo) begin
            if (tok_phase == PH_SUFFIX) begin
                tok_err = 1'b1;
            end else begin
                tok_phase = PH_NUMERAL;
                np = numeral_after(tok_pattern, (c == CHAR_UPPER_V) || (c == CHAR_LOWER_V));
                if (np == 3'd0) tok_err = 1'b1;
                else tok_pattern = np;
                tok_case |= is_up ? 2'b01 : 2'b10;
            end
        end else begin
            tok_err = 1'b1;
        end
        if (!last) return 1'b0;
        ok = !tok_err && (tok_phase != PH_PREFIX) && (tok_pattern != 3'd0) &&
             (tok_kinds != 2'b11) && (tok_case != 2'b11) && (tok_len <= MAX_LEN);
        if (ok) begin
            res.valid_res = 1'b1;
            res.degree    = tok_pattern;
            res.major     = (tok_case == 2'b01);
            if (tok_kinds == 2'b01) res.accidental_offset = {1'b0, tok_acc};
            else if (tok_kinds == 2'b10) res.accidental_offset = -{1'b0, tok_acc};
        end
        tok_phase   = PH_PREFIX;
        tok_pattern = 3'd0;
        tok_case    = 2'b00;
        tok_acc     = 4'd0;
        tok_kinds   = 2'b00;
        tok_prefix  = 1'b0;
        tok_len     = 0;
        tok_err     = 1'b0;
        return 1'b1;
    endfunction

    // Mostly short idle spells, a few long ones, none at all in a quiet stretch.
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string numeral_text(input int deg);
        case (deg)
            1:       return "I";
            2:       return "II";
            3:       return "III";
            4:       return "IV";
            5:       return "V";
            6:       return "VI";
            default: return "VII";
        endcase
    endfunction

    task automatic add_accs(input int n, input logic [7:0] kind, input bit mixed);
        repeat (n) begin
            if (mixed && $urandom_range(0, 1)) begin
                tok_chars = {tok_chars, ((kind == CHAR_SHARP) ? CHAR_FLAT : CHAR_SHARP)};
            end else begin
                tok_chars = {tok_chars, kind};
            end
        end
    endtask

    // Mostly well-formed chords with random content; the rest noise or broken.
    task automatic gen_token();
        int         n;
        int         run;
        int         pre_n;
        int         suf_n;
        bit         lower;
        bit         mixed;
        bit         flip;
        logic [7:0] kind;
        logic [7:0] ch;
        string      num;
        tok_chars.delete();
        if ($urandom_range(0, 99) < 20) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            repeat (n) begin
                if ($urandom_range(0, 1)) tok_chars = {tok_chars, 8'($urandom_range(0, 255))};
                else tok_chars = {tok_chars, SYMBOLS[$urandom_range(0, 5)]};
            end
            return;
        end
        kind  = $urandom_range(0, 1) ? CHAR_SHARP : CHAR_FLAT;
        mixed = ($urandom_range(0, 19) == 0);
        run   = ($urandom_range(0, 29) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
        pre_n = 0;
        suf_n = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5: pre_n = run;
            6, 7, 8: suf_n = run;
            default: begin
                pre_n = run;
                suf_n = $urandom_range(1, 2);
            end
        endcase
        lower = $urandom_range(0, 1);
        flip  = ($urandom_range(0, 19) == 0);
        num   = numeral_text($urandom_range(1, 7));
        add_accs(pre_n, kind, mixed);
        for (int k = 0; k < num.len(); k++) begin
            ch = num[k];
            if (lower ^ (flip && k == num.len() - 1)) ch |= 8'h20;
            tok_chars = {tok_chars, ch};
        end
        add_accs(suf_n, kind, mixed);
        if ($urandom_range(0, 19) == 0) begin
            tok_chars[$urandom_range(0, tok_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // Offers one item from a falling edge and returns at the falling edge after it is taken.
    task automatic send_item(input logic [7:0] c, input bit last, input bit typed,
                             input chord_result_t res);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= c;
        s_tlast   <= last;
        cur_typed = typed;
        cur_res   = res;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin : result_ready
        int stall;
        @(posedge aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8))
                @(negedge aclk);
            stall = idle_len();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // Results are checked before the input item of the same edge is predicted.
    always @(posedge aclk) begin : monitor
        chord_result_t got;
        chord_result_t want;
        chord_result_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[2:0], m_tdata[3], m_tdata[8:4]};
                if (chord_q.size() == 0) begin
                    $error("result item with no token pending");
                    fail_cnt++;
                end else begin
                    want = chord_q.pop_front();
                    chords_seen++;
                    if (got.valid_res) chords_valid++;
                    if (got.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
                        fail_cnt++;
                    end
                    if (got.degree !== want.degree) begin
                        $error("degree: expected %0d, got %0d", want.degree, got.degree);
                        fail_cnt++;
                    end
                    if (got.major !== want.major) begin
                        $error("major: expected %0d, got %0d", want.major, got.major);
                        fail_cnt++;
                    end
                    if (got.accidental_offset !== want.accidental_offset) begin
                        $error("accidental_offset: expected %0d, got %0d",
                               want.accidental_offset, got.accidental_offset);
                        fail_cnt++;
                    end
                    if (m_tdata[15:9] !== 7'd0) begin
                        $error("tdata padding: expected 0, got %0h", m_tdata[15:9]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                chars_seen++;
                if (parse_char(s_tdata, s_tlast, pred)) begin
                    chord_q = {chord_q, (cur_typed ? cur_res : pred)};
                end
            end
        end
    end

    initial begin : stimulus
        int waited;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
        end
        while (chars_sent < RAND_ITEMS) begin
            quiet = ($urandom_range(0, 9) == 0);
            gen_token();
            foreach (tok_chars[k]) begin
                send_item(tok_chars[k], k == tok_chars.size() - 1, 1'b0, NO_CHORD);
            end
            chars_sent += tok_chars.size();
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;
        waited = 0;
        while (chord_q.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        if (chord_q.size() != 0) begin
            $error("%0d expected chords never arrived", chord_q.size());
            fail_cnt++;
        end
        repeat (5) @(posedge aclk);
        $display("Fed %0d characters; checked %0d chord results, %0d valid and %0d rejected.",
                 chars_seen, chords_seen, chords_valid, chords_seen - chords_valid);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rncp_pkg.sv
src/rncp_step.sv
src/roman_numeral_chord_parser_core.sv
dv/roman_numeral_chord_parser_core_test.sv
